// ===== design/vpn_pkg.sv =====
// ----------------------------------------------------------------------------
// vpn_pkg
// Shared types, constants and the arctangent table for the polar pipeline.
// ----------------------------------------------------------------------------
package vpn_pkg;

    localparam int CORDIC_CELLS = 16;
    localparam int SQRT_CELLS   = 32;
    localparam int DIV_CELLS    = 16;
    // input register + cordic + root + decision stage + divider + output register
    localparam int LATENCY      = 1 + CORDIC_CELLS + SQRT_CELLS + 1 + DIV_CELLS + 1;

    localparam logic [15:0] UNIT_ONE = 16'd16384;

    // word carried through the cordic and root cells
    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic        [31:0] s;
        logic signed [43:0] cx;
        logic signed [43:0] cy;
        logic        [31:0] z;
        logic               zero;
        logic        [35:0] rem;
        logic        [31:0] root;
        logic        [15:0] mag;
    } t_item;

    // word carried through the divider cells
    typedef struct packed {
        logic               neg_x;
        logic               neg_y;
        logic        [15:0] angle;
        logic        [15:0] mag;
        logic               norm;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic        [31:0] root;
        logic        [47:0] remx;
        logic        [47:0] remy;
        logic        [15:0] qx;
        logic        [15:0] qy;
    } t_div;

    // atan(2^-k) as a 32-bit binary angle
    function automatic logic [31:0] atan_entry(input logic [3:0] k);
        logic [31:0] v;
        case (k)
            4'd0:    v = 32'd536870912;
            4'd1:    v = 32'd316933406;
            4'd2:    v = 32'd167458907;
            4'd3:    v = 32'd85004756;
            4'd4:    v = 32'd42667331;
            4'd5:    v = 32'd21354465;
            4'd6:    v = 32'd10679838;
            4'd7:    v = 32'd5340245;
            4'd8:    v = 32'd2670163;
            4'd9:    v = 32'd1335087;
            4'd10:   v = 32'd667544;
            4'd11:   v = 32'd333772;
            4'd12:   v = 32'd166886;
            4'd13:   v = 32'd83443;
            4'd14:   v = 32'd41722;
            4'd15:   v = 32'd20861;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/vpn_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// vpn_cordic_cell
// One vectoring micro-rotation, registered.
// ----------------------------------------------------------------------------
module vpn_cordic_cell import vpn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [3:0]  i_stage,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic signed [43:0] dx;
    logic signed [43:0] dy;

    always_comb begin
        dx     = i_item.cy >>> i_stage;
        dy     = i_item.cx >>> i_stage;
        n_item = i_item;
        if (!i_item.cy[43]) begin
            n_item.cx = i_item.cx + dx;
            n_item.cy = i_item.cy - dy;
            n_item.z  = i_item.z + atan_entry(i_stage);
        end else begin
            n_item.cx = i_item.cx - dx;
            n_item.cy = i_item.cy + dy;
            n_item.z  = i_item.z - atan_entry(i_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/vpn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// vpn_sqrt_cell
// One digit of the restoring square root of s * 2^32, registered.
// ----------------------------------------------------------------------------
module vpn_sqrt_cell import vpn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_stage,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic [1:0]  pair;
    logic [35:0] remw;
    logic [35:0] trial;
    logic [31:0] shifted;

    always_comb begin
        // radicand pairs come from s for the upper half, zeros below
        shifted = i_item.s >> (5'd30 - {i_stage[3:0], 1'b0});
        pair    = i_stage[4] ? 2'b00 : shifted[1:0];
        remw    = {i_item.rem[33:0], pair};
        trial   = {2'b00, i_item.root, 2'b01};
        n_item  = i_item;
        if (remw >= trial) begin
            n_item.rem  = remw - trial;
            n_item.root = {i_item.root[30:0], 1'b1};
        end else begin
            n_item.rem  = remw;
            n_item.root = {i_item.root[30:0], 1'b0};
        end
        // halfway point: integer root of s and its remainder, round to nearest
        if (i_stage == 5'd15) begin
            n_item.mag = n_item.root[15:0]
                       + 16'(n_item.rem > {20'd0, n_item.root[15:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/vpn_div_cell.sv =====
// ----------------------------------------------------------------------------
// vpn_div_cell
// One quotient bit of both restoring divisions, registered.
// ----------------------------------------------------------------------------
module vpn_div_cell import vpn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [3:0]  i_stage,
    input  logic        i_valid,
    input  t_div        i_item,
    output logic        o_valid,
    output t_div        o_item
);

    logic  r_valid;
    t_div  r_item;
    t_div  n_item;
    logic [47:0] dsh;

    always_comb begin
        dsh    = {16'd0, i_item.root} << i_stage;
        n_item = i_item;
        if (i_item.remx >= dsh) begin
            n_item.remx = i_item.remx - dsh;
            n_item.qx   = i_item.qx | (16'd1 << i_stage);
        end
        if (i_item.remy >= dsh) begin
            n_item.remy = i_item.remy - dsh;
            n_item.qy   = i_item.qy | (16'd1 << i_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/vector_polar_and_normalize.sv =====
// ----------------------------------------------------------------------------
// vector_polar_and_normalize
// Magnitude, binary angle and unit vector of a Q7.8 vector, fully pipelined.
// ----------------------------------------------------------------------------
// Path: input register, cordic, root, decision, divider and output stages.
// Throughput: one word per cycle; o_busy is never raised, the chain of
//   cordic, root and divider cells moves every cycle.
// Reset (synchronous, active low) clears all valid bits and min_magnitude.
// Results are shown for one cycle on o_done; the receiver cannot stall.
module vector_polar_and_normalize import vpn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [15:0] i_cfg_data,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_vec_x,
    input  logic signed [15:0] i_vec_y,
    output logic               o_done,
    output logic        [15:0] o_magnitude,
    output logic signed [15:0] o_angle,
    output logic signed [15:0] o_unit_x,
    output logic signed [15:0] o_unit_y,
    output logic               o_was_normalized
);

    // --- configuration: threshold, taken any time
    logic [15:0] r_min_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mag <= 16'd0;
        end else if (i_cfg_valid) begin
            r_min_mag <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    // --- input stage: squares, fold into right half plane, scale for cordic
    logic               accept;
    logic signed [43:0] sx;
    logic signed [43:0] sy;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    t_item              n_in;
    t_item              r_in;
    logic               r_in_valid;

    assign accept = i_start && !o_busy;

    always_comb begin
        sx = {{28{i_vec_x[15]}}, i_vec_x};
        sy = {{28{i_vec_y[15]}}, i_vec_y};
        xx = i_vec_x * i_vec_x;
        yy = i_vec_y * i_vec_y;
        n_in      = '0;
        n_in.vx   = i_vec_x;
        n_in.vy   = i_vec_y;
        n_in.s    = 32'(xx) + 32'(yy);
        n_in.zero = (i_vec_x == 16'sd0) && (i_vec_y == 16'sd0);
        if (i_vec_x[15]) begin
            // negate and start from pi
            n_in.cx = (-sx) <<< 24;
            n_in.cy = (-sy) <<< 24;
            n_in.z  = 32'h8000_0000;
        end else begin
            n_in.cx = sx <<< 24;
            n_in.cy = sy <<< 24;
            n_in.z  = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
        r_in <= n_in;
    end

    // --- cordic cells, then root cells, as one chain
    logic  chain_valid [CORDIC_CELLS + SQRT_CELLS + 1];
    t_item chain_item  [CORDIC_CELLS + SQRT_CELLS + 1];

    assign chain_valid[0] = r_in_valid;
    assign chain_item[0]  = r_in;

    for (genvar g = 0; g < CORDIC_CELLS; g++) begin : g_cordic
        vpn_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (4'(g)),
            .i_valid (chain_valid[g]),
            .i_item  (chain_item[g]),
            .o_valid (chain_valid[g + 1]),
            .o_item  (chain_item[g + 1])
        );
    end

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        vpn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (5'(g)),
            .i_valid (chain_valid[CORDIC_CELLS + g]),
            .i_item  (chain_item[CORDIC_CELLS + g]),
            .o_valid (chain_valid[CORDIC_CELLS + g + 1]),
            .o_item  (chain_item[CORDIC_CELLS + g + 1])
        );
    end

    // --- decision stage: threshold, angle rounding, passthrough, dividends
    t_item              tail;
    t_div               n_dec;
    t_div               r_dec;
    logic               r_dec_valid;
    logic signed [21:0] px_w;
    logic signed [21:0] py_w;
    logic        [15:0] ax;
    logic        [15:0] ay;
    logic        [31:0] zr;

    function automatic logic signed [15:0] sat_unit(input logic signed [21:0] v);
        logic signed [15:0] res;
        if (v > 22'sd16384) begin
            res = 16'sd16384;
        end else if (v < -22'sd16384) begin
            res = -16'sd16384;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    always_comb begin
        tail  = chain_item[CORDIC_CELLS + SQRT_CELLS];
        px_w  = {{6{tail.vx[15]}}, tail.vx} <<< 6;
        py_w  = {{6{tail.vy[15]}}, tail.vy} <<< 6;
        ax    = tail.vx[15] ? 16'(-tail.vx) : 16'(tail.vx);
        ay    = tail.vy[15] ? 16'(-tail.vy) : 16'(tail.vy);
        zr    = tail.z + 32'h0000_8000;
        n_dec = '0;
        n_dec.neg_x = tail.vx[15];
        n_dec.neg_y = tail.vy[15];
        n_dec.angle = tail.zero ? 16'd0 : zr[31:16];
        n_dec.mag   = tail.mag;
        n_dec.norm  = tail.mag > r_min_mag;
        n_dec.px    = sat_unit(px_w);
        n_dec.py    = sat_unit(py_w);
        n_dec.root  = tail.root;
        // |c| * 2^30 plus half the divisor for round-to-nearest
        n_dec.remx  = {2'b00, ax, 30'd0} + {17'd0, tail.root[31:1]};
        n_dec.remy  = {2'b00, ay, 30'd0} + {17'd0, tail.root[31:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else begin
            r_dec_valid <= chain_valid[CORDIC_CELLS + SQRT_CELLS];
        end
        r_dec <= n_dec;
    end

    // --- divider cells, most significant quotient bit first
    logic div_valid [DIV_CELLS + 1];
    t_div div_item  [DIV_CELLS + 1];

    assign div_valid[0] = r_dec_valid;
    assign div_item[0]  = r_dec;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        vpn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (4'(DIV_CELLS - 1 - g)),
            .i_valid (div_valid[g]),
            .i_item  (div_item[g]),
            .o_valid (div_valid[g + 1]),
            .o_item  (div_item[g + 1])
        );
    end

    // --- output register: clamp, restore sign, pick normalised or passthrough
    t_div               dtail;
    logic        [15:0] qxc;
    logic        [15:0] qyc;
    logic               r_done;
    logic        [15:0] r_mag;
    logic signed [15:0] r_angle;
    logic signed [15:0] r_ux;
    logic signed [15:0] r_uy;
    logic               r_norm;
    logic signed [15:0] n_ux;
    logic signed [15:0] n_uy;

    always_comb begin
        dtail = div_item[DIV_CELLS];
        qxc   = (dtail.qx > UNIT_ONE) ? UNIT_ONE : dtail.qx;
        qyc   = (dtail.qy > UNIT_ONE) ? UNIT_ONE : dtail.qy;
        if (dtail.norm) begin
            n_ux = dtail.neg_x ? -$signed(qxc) : $signed(qxc);
            n_uy = dtail.neg_y ? -$signed(qyc) : $signed(qyc);
        end else begin
            n_ux = dtail.px;
            n_uy = dtail.py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= div_valid[DIV_CELLS];
        end
        r_mag   <= dtail.mag;
        r_angle <= dtail.angle;
        r_ux    <= n_ux;
        r_uy    <= n_uy;
        r_norm  <= dtail.norm;
    end

    assign o_done           = r_done;
    assign o_magnitude      = r_mag;
    assign o_angle          = r_angle;
    assign o_unit_x         = r_ux;
    assign o_unit_y         = r_uy;
    assign o_was_normalized = r_norm;

    // --- checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("accepted word did not emerge after the pipeline latency");

    a_norm_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_was_normalized |-> o_magnitude > r_min_mag)
        else $error("normalised word without magnitude above threshold");

    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_magnitude == 16'd0) |-> (o_angle == 16'sd0) && !o_was_normalized)
        else $error("zero vector gave non-zero angle or was normalised");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_unit_x <= 16'sd16384) && (o_unit_x >= -16'sd16384)
                && (o_unit_y <= 16'sd16384) && (o_unit_y >= -16'sd16384))
        else $error("unit component outside Q1.14 range");

endmodule
